FILE: rtl/core/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types, codes and the texture gamma table of the palette expander.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned ENTRY_W   = 24;

  localparam logic [ADDR_W-1:0] KEY_INDEX  = 8'hFF;
  localparam logic [7:0]        FULL_ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_GAMMA    = 2'd1,
    MODE_GRADIENT = 2'd2,
    MODE_MASKED   = 2'd3
  } render_mode_e;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] entry_index;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic [7:0] pix_alpha;
  } pix_out_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr;
  } ram_req_t;

  typedef logic [7:0] gamma_rom_t [PAL_DEPTH];

  // Entry c is the largest v with v^5 <= 255 * c^4, evaluated at elaboration.
  function automatic gamma_rom_t gamma_rom_build();
    gamma_rom_t      rom;
    longint unsigned x;
    longint unsigned lim;
    longint unsigned t;
    logic [7:0]      v;
    for (int c = 0; c < PAL_DEPTH; c++) begin
      x   = longint'(c);
      lim = 64'd255 * x * x * x * x;
      v   = 8'd0;
      for (int b = 7; b >= 0; b--) begin
        t = {56'd0, v | (8'd1 << b)};
        if (t * t * t * t * t <= lim) begin
          v = v | (8'd1 << b);
        end
      end
      rom[c] = v;
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = gamma_rom_build();

endpackage

`default_nettype wire

FILE: rtl/core/pce_palette_ram.sv
// ----------------------------------------------------------------------------
// pce_palette_ram
// 256 x 24 palette memory with registered read. Per-entry valid
// flags make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_palette_ram (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire pce_pkg::ram_req_t               req,
  output logic [pce_pkg::ENTRY_W-1:0]          rdata
);

  logic [pce_pkg::ENTRY_W-1:0] mem [pce_pkg::PAL_DEPTH];
  logic [pce_pkg::PAL_DEPTH-1:0] valid;
  logic [pce_pkg::ENTRY_W-1:0] rd_word;
  logic                        rd_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_word <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      rd_valid <= valid[req.raddr];
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

FILE: rtl/core/palette_clut_expander.sv
// ----------------------------------------------------------------------------
// palette_clut_expander
// Indexed-color expander: 8-bit index to RGBA through a 256-entry palette.
// ----------------------------------------------------------------------------
// The block takes one word per clock and busy stays low. A load word writes
// its palette entry at the accepting edge and gives no result. A lookup word
// gives its result through the palette read register and then the output
// register, shown for one cycle with done high.
// The receiver cannot stall, so it must take every result as it appears.
// After reset every entry reads as black at once; there is no clearing pass.
// Write render_mode only while no lookup is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_clut_expander (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire pce_pkg::pix_in_t  request,
  input  wire logic              mode_we,
  input  wire logic [1:0]        mode_wdata,
  output logic                   done,
  output pce_pkg::pix_out_t      result
);

  pce_pkg::render_mode_e       mode;
  pce_pkg::ram_req_t           ram_req;
  logic [pce_pkg::ENTRY_W-1:0] rdata;
  logic                        accept;
  logic                        rd_pending;
  logic [7:0]                  rd_index;
  logic [7:0]                  ch_red;
  logic [7:0]                  ch_green;
  logic [7:0]                  ch_blue;
  pce_pkg::pix_out_t           result_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pce_pkg::MODE_NORMAL;
    end else if (mode_we) begin
      mode <= pce_pkg::render_mode_e'(mode_wdata);
    end
  end

  always_comb begin
    ram_req.we    = accept && (request.func == pce_pkg::FUNC_LOAD);
    ram_req.waddr = request.entry_index;
    ram_req.wdata = {request.load_red, request.load_green, request.load_blue};
    ram_req.raddr = (mode == pce_pkg::MODE_GRADIENT) ? pce_pkg::KEY_INDEX
                                                     : request.entry_index;
  end

  pce_palette_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= accept && (request.func == pce_pkg::FUNC_LOOKUP);
    end
    rd_index <= request.entry_index;
  end

  assign ch_red   = rdata[23:16];
  assign ch_green = rdata[15:8];
  assign ch_blue  = rdata[7:0];

  always_comb begin
    result_next.pix_red   = ch_red;
    result_next.pix_green = ch_green;
    result_next.pix_blue  = ch_blue;
    result_next.pix_alpha = pce_pkg::FULL_ALPHA;
    case (mode)
      pce_pkg::MODE_GAMMA: begin
        result_next.pix_red   = pce_pkg::GAMMA_ROM[ch_red];
        result_next.pix_green = pce_pkg::GAMMA_ROM[ch_green];
        result_next.pix_blue  = pce_pkg::GAMMA_ROM[ch_blue];
      end
      pce_pkg::MODE_GRADIENT: begin
        result_next.pix_alpha = rd_index;
      end
      pce_pkg::MODE_MASKED: begin
        if (rd_index == pce_pkg::KEY_INDEX) begin
          result_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_pending;
    end
    result <= result_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/pce_checker.sv
// ----------------------------------------------------------------------------
// pce_checker
// Port-level checks of the palette expander, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire pce_pkg::pix_in_t  request,
  input wire logic              done,
  input wire pce_pkg::pix_out_t result
);

  a_lookup_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.func == pce_pkg::FUNC_LOOKUP |-> ##2 done)
    else $error("lookup word did not give a result");

  a_load_gives_none: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.func == pce_pkg::FUNC_LOAD |-> ##2 !done)
    else $error("load word gave a result");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && request.func == pce_pkg::FUNC_LOOKUP, 2))
    else $error("result without a lookup word");

  a_alpha_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.pix_alpha == pce_pkg::FULL_ALPHA
              || result.pix_alpha == $past(request.entry_index, 2)
              || (result.pix_alpha == 8'd0 && result.pix_red == 8'd0
                  && result.pix_green == 8'd0 && result.pix_blue == 8'd0)))
    else $error("alpha does not match any render mode");

endmodule

bind palette_clut_expander pce_checker u_pce_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire
